// ===== rtl/tmpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmpf_pkg
// Shared constants and types of the temporal median pixel filter.
// ----------------------------------------------------------------------------
`default_nettype none
package tmpf_pkg;
	localparam int SAMPLE_W     = 8;
	localparam int FRAME_W      = 13;
	localparam int WINDOW_DEF   = 9;
	localparam int PIXELS_DEF   = 4096;
	localparam logic [FRAME_W-1:0] FRAME_RESET = 13'd4096;

	typedef struct packed {
		logic                valid;
		logic                last;
		logic [SAMPLE_W-1:0] mid;
	} ring_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/tmpf_ram.sv =====
// ----------------------------------------------------------------------------
// tmpf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tmpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tmpf_ring.sv =====
// ----------------------------------------------------------------------------
// tmpf_ring
// Pixel position tracking and per-pixel sample ring with write-back bypass.
// ----------------------------------------------------------------------------
`default_nettype none
module tmpf_ring import tmpf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	parameter int PIXELS = PIXELS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [SAMPLE_W-1:0]        sample,
	input  wire logic [FRAME_W-1:0]         frame_pixels,
	output ring_ctl_t                       ctl,
	output logic [WINDOW-1:0][SAMPLE_W-1:0] word
);
	localparam int PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = (PW + 1 > FRAME_W) ? PW + 1 : FRAME_W;
	localparam int WW = WINDOW * SAMPLE_W;

	logic [PW-1:0] pos_q;
	logic [SW-1:0] slot_q;
	logic [PW:0]   fill_q;
	logic          accept;
	logic [CW-1:0] active;
	logic [CW-1:0] pos_next;
	logic          last;

	logic                v_s1;
	logic [PW-1:0]       pos_s1;
	logic [SW-1:0]       slot_s1;
	logic [SAMPLE_W-1:0] fresh_s1;
	logic                last_s1;
	logic                filled_s1;

	logic          byp_v_q;
	logic [PW-1:0] byp_addr_q;
	logic [WW-1:0] byp_word_q;
	logic [WW-1:0] rdata;
	logic [WW-1:0] old_word;
	logic [WINDOW-1:0][SAMPLE_W-1:0] new_word;
	logic [SW:0]   mid_sum;
	logic [SW-1:0] mid_slot;

	assign accept = en && in_valid;

	always_comb begin
		if (frame_pixels == '0) begin
			active = CW'(1);
		end else if (CW'(frame_pixels) > CW'(PIXELS)) begin
			active = CW'(PIXELS);
		end else begin
			active = CW'(frame_pixels);
		end
		pos_next = CW'(pos_q) + CW'(1);
		last     = pos_next >= active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			slot_q <= '0;
			fill_q <= '0;
			v_s1   <= 1'b0;
			byp_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= accept;
			end
			if (accept) begin
				if ({1'b0, pos_q} == fill_q) begin
					fill_q <= fill_q + 1'b1;
				end
				if (last) begin
					pos_q  <= '0;
					slot_q <= (32'(slot_q) + 1 >= WINDOW) ? '0 : slot_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (en && v_s1) begin
				byp_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1    <= pos_q;
			slot_s1   <= slot_q;
			fresh_s1  <= sample;
			last_s1   <= last;
			filled_s1 <= {1'b0, pos_q} < fill_q;
		end
		if (en && v_s1) begin
			byp_addr_q <= pos_s1;
			byp_word_q <= new_word;
		end
	end

	tmpf_ram #(
		.WIDTH(WW),
		.DEPTH(PIXELS)
	) u_ram (
		.clk  (clk),
		.we   (en && v_s1),
		.waddr(pos_s1),
		.wdata(new_word),
		.re   (accept),
		.raddr(pos_q),
		.rdata(rdata)
	);

	always_comb begin
		if (byp_v_q && byp_addr_q == pos_s1) begin
			old_word = byp_word_q;
		end else if (filled_s1) begin
			old_word = rdata;
		end else begin
			old_word = '0;
		end
		new_word = old_word;
		new_word[slot_s1] = fresh_s1;
		mid_sum = (SW+1)'(slot_s1) + (SW+1)'(1 + WINDOW / 2);
		if (32'(mid_sum) >= WINDOW) begin
			mid_slot = SW'(mid_sum - (SW+1)'(WINDOW));
		end else begin
			mid_slot = SW'(mid_sum);
		end
	end

	assign word      = new_word;
	assign ctl.valid = v_s1;
	assign ctl.last  = last_s1;
	assign ctl.mid   = new_word[mid_slot];
endmodule
`default_nettype wire

// ===== rtl/tmpf_rank.sv =====
// ----------------------------------------------------------------------------
// tmpf_rank
// Pipelined order-statistic selection of the median from the window samples.
// ----------------------------------------------------------------------------
`default_nettype none
module tmpf_rank import tmpf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire ring_ctl_t                  in_ctl,
	input  wire logic [WINDOW-1:0][SAMPLE_W-1:0] in_word,
	output ring_ctl_t                       out_ctl,
	output logic [SAMPLE_W-1:0]             median
);
	localparam int RW   = $clog2(WINDOW + 1);
	localparam int NEED = WINDOW / 2 + 1;

	ring_ctl_t                       ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [WINDOW-1:0][SAMPLE_W-1:0] word_s2, word_s3, word_s4;
	logic [WINDOW-1:0][WINDOW-1:0]   lt_s3;
	logic [WINDOW-1:0][RW-1:0]       rank_s4;
	logic [SAMPLE_W-1:0]             med_s5;
	logic [WINDOW-1:0][WINDOW-1:0]   lt_c;
	logic [WINDOW-1:0][RW-1:0]       rank_c;
	logic [SAMPLE_W-1:0]             med_c;

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			for (int j = 0; j < WINDOW; j++) begin
				lt_c[i][j] = (word_s2[j] < word_s2[i]) ||
					((word_s2[j] == word_s2[i]) && (j < i));
			end
			rank_c[i] = RW'($countones(lt_s3[i]));
		end
		med_c = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (rank_s4[i] == RW'(NEED - 1)) begin
				med_c = med_c | word_s4[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s2 <= in_ctl;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s2 <= in_word;
			word_s3 <= word_s2;
			lt_s3   <= lt_c;
			word_s4 <= word_s3;
			rank_s4 <= rank_c;
			med_s5  <= med_c;
		end
	end

	assign out_ctl = ctl_s5;
	assign median  = med_s5;
endmodule
`default_nettype wire

// ===== rtl/temporal_median_pixel_filter_core.sv =====
// ----------------------------------------------------------------------------
// temporal_median_pixel_filter_core
// Temporal median over a window of frames for each pixel of a raster stream.
// ----------------------------------------------------------------------------
// Pipeline: five register stages, ring stage s1 and rank stages s2 to s5, all
// held while the output stalls. Throughput: one pixel per cycle unless the
// output stalls, set by the single read and write port of the sample ring
// memory with a one-entry write-back bypass.
// Reset clears the pipeline valid bits and the position counters; ring words
// beyond the fill count read as zero, so no clearing pass is needed.
`default_nettype none
module temporal_median_pixel_filter_core import tmpf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	parameter int PIXELS = PIXELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // sample
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             m_tdata,   // middle_sample in [15:8], median_value in [7:0]
	output logic                    m_tlast,   // frame_end
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [FRAME_W-1:0] cfg_data   // frame_pixels
);
	logic [FRAME_W-1:0]              frame_pixels_q;
	logic                            en;
	ring_ctl_t                       ring_ctl;
	ring_ctl_t                       out_ctl;
	logic [WINDOW-1:0][SAMPLE_W-1:0] ring_word;
	logic [SAMPLE_W-1:0]             median;

	assign cfg_ready = 1'b1;
	assign en        = !out_ctl.valid || m_tready;
	assign s_tready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FRAME_RESET;
		end else if (cfg_valid) begin
			frame_pixels_q <= cfg_data;
		end
	end

	tmpf_ring #(
		.WINDOW(WINDOW),
		.PIXELS(PIXELS)
	) u_ring (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_tvalid),
		.sample      (s_tdata),
		.frame_pixels(frame_pixels_q),
		.ctl         (ring_ctl),
		.word        (ring_word)
	);

	tmpf_rank #(
		.WINDOW(WINDOW)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_ctl (ring_ctl),
		.in_word(ring_word),
		.out_ctl(out_ctl),
		.median (median)
	);

	assign m_tvalid = out_ctl.valid;
	assign m_tdata  = {out_ctl.mid, median};
	assign m_tlast  = out_ctl.last;
endmodule
`default_nettype wire

// ===== bench/tb_temporal_median_pixel_filter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Temporal median pixel filter testbench
// Drives pixel and frame-size transactions through the streaming ports, keeps
// its own per-pixel sample ring and histogram to predict each result, and
// checks every output transaction in order against that prediction or a fixed directed result.
// ----------------------------------------------------------------------------
module tb_temporal_median_pixel_filter_core import tmpf_pkg::*; ();

	localparam int WIN = 9;
	localparam int NPIX = 4096;
	localparam int NEED = WIN / 2 + 1;
	localparam int LATENCY = 5;
	localparam int STALL_LIMIT = 2000;
	localparam bit ROW_PIX = 1'b0;
	localparam bit ROW_CFG = 1'b1;

	typedef struct packed {
		logic [7:0] median;
		logic [7:0] middle;
		logic       frame_end;
	} pixel_result_t;

	typedef struct {
		bit          kind;
		logic [12:0] val;
		bit          fixed;
		pixel_result_t res;
	} dir_row_t;

	localparam int NDIR = 24;
	dir_row_t dir_rows [0:NDIR-1] = '{
		'{ROW_PIX, 13'd255, 1'b1, '{8'd0, 8'd0, 1'b0}},
		'{ROW_PIX, 13'd0,   1'b1, '{8'd0, 8'd0, 1'b0}},
		'{ROW_PIX, 13'd255, 1'b1, '{8'd0, 8'd0, 1'b0}},
		'{ROW_CFG, 13'd0,   1'b0, '0},
		'{ROW_PIX, 13'd255, 1'b0, '0},
		'{ROW_PIX, 13'd255, 1'b0, '0},
		'{ROW_PIX, 13'd255, 1'b0, '0},
		'{ROW_PIX, 13'd255, 1'b0, '0},
		'{ROW_PIX, 13'd255, 1'b0, '0},
		'{ROW_PIX, 13'd255, 1'b0, '0},
		'{ROW_PIX, 13'd255, 1'b0, '0},
		'{ROW_PIX, 13'd255, 1'b0, '0},
		'{ROW_PIX, 13'd255, 1'b0, '0},
		'{ROW_PIX, 13'd0,   1'b0, '0},
		'{ROW_PIX, 13'd0,   1'b0, '0},
		'{ROW_PIX, 13'd0,   1'b0, '0},
		'{ROW_PIX, 13'd0,   1'b0, '0},
		'{ROW_PIX, 13'd0,   1'b0, '0},
		'{ROW_PIX, 13'd0,   1'b0, '0},
		'{ROW_CFG, 13'd8191, 1'b0, '0},
		'{ROW_PIX, 13'd170, 1'b0, '0},
		'{ROW_PIX, 13'd85,  1'b0, '0},
		'{ROW_CFG, 13'd3,   1'b0, '0},
		'{ROW_PIX, 13'd128, 1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [FRAME_W-1:0] cfg_data;

	temporal_median_pixel_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	byte unsigned sample_ring [WIN*NPIX];
	byte unsigned bin_count [NPIX*256];
	int unsigned cur_slot;
	int unsigned cur_pos;
	logic [12:0] frame_size;
	pixel_result_t expected_q [$];
	int mismatches;
	int stall_cycles;
	bit quiet;
	bit pending_fixed;
	pixel_result_t pending_res;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_model();
		foreach (sample_ring[i]) sample_ring[i] = 0;
		foreach (bin_count[i]) bin_count[i] = 0;
		for (int p = 0; p < NPIX; p++) bin_count[p*256] = 8'(WIN);
		cur_slot = 0;
		cur_pos = 0;
		frame_size = FRAME_RESET;
	endfunction

	function automatic pixel_result_t predict_median(input byte unsigned fresh);
		pixel_result_t r;
		int unsigned cellx;
		int unsigned base;
		int unsigned cum;
		int unsigned mslot;
		int unsigned active;
		byte unsigned stale;
		cellx = cur_slot * NPIX + cur_pos;
		base = cur_pos * 256;
		stale = sample_ring[cellx];
		sample_ring[cellx] = fresh;
		if (bin_count[base+stale] > 0) bin_count[base+stale]--;
		if (bin_count[base+fresh] < 15) bin_count[base+fresh]++;
		r.median = 8'd255;
		cum = 0;
		for (int v = 0; v < 256; v++) begin
			cum += bin_count[base+v];
			if (cum >= NEED) begin
				r.median = v[7:0];
				break;
			end
		end
		mslot = (cur_slot + 1 + WIN / 2) % WIN;
		r.middle = sample_ring[mslot*NPIX+cur_pos];
		active = (frame_size == 0) ? 1 : (frame_size > NPIX) ? NPIX : frame_size;
		r.frame_end = (cur_pos + 1 >= active);
		if (r.frame_end) begin
			cur_pos = 0;
			cur_slot = (cur_slot + 1 >= WIN) ? 0 : cur_slot + 1;
		end else begin
			cur_pos = cur_pos + 1;
		end
		return r;
	endfunction

	task automatic idle_burst();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	task automatic send_pixel(input logic [7:0] value);
		idle_burst();
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_frame_size(input logic [12:0] value);
		s_tvalid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (LATENCY + 3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		frame_size = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		pixel_result_t e;
		if (arst_n && s_tvalid && s_tready) begin
			e = predict_median(s_tdata);
			expected_q.push_back(pending_fixed ? pending_res : e);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transaction: median %0d middle %0d last %0b",
						m_tdata[7:0], m_tdata[15:8], m_tlast);
			end else begin
				e = expected_q.pop_front();
				if (m_tdata[7:0] !== e.median || m_tdata[15:8] !== e.middle ||
						m_tlast !== e.frame_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
							e.median, e.middle, e.frame_end,
							m_tdata[7:0], m_tdata[15:8], m_tlast);
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		logic [12:0] sizes [8];
		byte unsigned base;
		int n;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		mismatches = 0;
		stall_cycles = 0;
		quiet = 1'b0;
		pending_fixed = 1'b0;
		clear_model();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NDIR; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_frame_size(dir_rows[i].val);
			end else begin
				pending_fixed = dir_rows[i].fixed;
				pending_res = dir_rows[i].res;
				send_pixel(dir_rows[i].val[7:0]);
				pending_fixed = 1'b0;
			end
		end

		sizes = '{13'd1, 13'd2, 13'd5, 13'd0, 13'd7, 13'd8191, 13'd3, 13'd4};
		for (int ph = 0; ph < 8; ph++) begin
			write_frame_size(sizes[ph]);
			if (ph == 7) quiet = 1'b1;
			n = (sizes[ph] > 13'd100) ? 40 : 250;
			for (int k = 0; k < n; k++) begin
				base = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 2) == 0)
					send_pixel(8'($urandom_range(0, 255)));
				else
					send_pixel(8'(base & 8'hF0 | $urandom_range(0, 15) ^ 8'((k % 3) * 85)));
			end
		end
		s_tvalid <= 1'b0;

		wait (expected_q.size() == 0);
		repeat (LATENCY * 4) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
